// ----- rtl/core/mhlp_pkg.sv -----
// types and constants shared by the manifest header line parser
package mhlp_pkg;

	// characters that steer the parse
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// output queue geometry
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	// result kinds
	typedef enum logic [2:0] {
		K_NAME    = 3'd0,
		K_VALUE   = 3'd1,
		K_PAIR    = 3'd2,
		K_SECTION = 3'd3,
		K_ERROR   = 3'd4
	} kind_t;

	// header phase, one-hot
	typedef enum logic [4:0] {
		PH_START = 5'b00001,
		PH_NAME  = 5'b00010,
		PH_COLON = 5'b00100,
		PH_VALUE = 5'b01000,
		PH_DONE  = 5'b10000
	} hphase_t;

	// line phase, one-hot
	typedef enum logic [2:0] {
		LN_INSIDE   = 3'b001,
		LN_AFTER_CR = 3'b010,
		LN_AFTER_NL = 3'b100
	} lphase_t;

	// one result entry
	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       last;
	} result_t;

endpackage

// ----- rtl/core/manifest_header_line_parser.sv -----
// manifest header line parser: byte stream in, tagged header characters out
//
// Takes one manifest byte per cycle into an input register, decides it against the
// parse state and writes zero, one or two results into a four-entry output queue. A
// new byte is taken every cycle while the queue holds at most two results, so the
// sustained rate is one byte per clock as long as the downstream side keeps up; a
// byte can give two results (pair complete followed by the next name character or
// section end). After reset, a section end or an error the block drops bytes until
// one arrives with the first flag set.
module manifest_header_line_parser import mhlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] first
	input  logic       s_tlast,   // end_of_data
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic [2:0] m_tuser,   // [2:0] kind
	output logic       m_tlast    // last
);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        eod_s1;

	// parse state
	hphase_t     hp_q;
	lphase_t     lp_q;
	logic        cont_q;

	// output queue
	result_t     fifo_q [QDEPTH];
	logic [QAW-1:0] head_q;
	logic [QAW-1:0] tail_q;
	logic [QAW:0]   count_q;

	logic        advance;
	logic        pop;

	// step results
	hphase_t     hp_n;
	lphase_t     lp_n;
	logic        cont_n;
	logic [1:0]  n_push;
	result_t     res0;
	result_t     res1;

	// input handshake
	assign advance  = valid_s1 && (count_q <= (QAW+1)'(QDEPTH - 2));
	assign s_tready = !valid_s1 || advance;
	assign pop      = m_tvalid && m_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			eod_s1   <= s_tlast;
		end
	end

	// one parse step
	always_comb begin
		logic       eod;
		logic       stop;
		logic       take;
		logic [1:0] n;
		kind_t      k0, k1;
		logic [7:0] c0, c1;
		logic       is_lf, is_cr;

		eod   = eod_s1 || (byte_s1 == CH_NUL);
		is_lf = byte_s1 == CH_LF;
		is_cr = byte_s1 == CH_CR;
		hp_n   = first_s1 ? PH_START : hp_q;
		lp_n   = first_s1 ? LN_INSIDE : lp_q;
		cont_n = first_s1 ? 1'b0 : cont_q;
		n    = 2'd0;
		k0   = K_NAME;
		k1   = K_NAME;
		c0   = 8'h00;
		c1   = 8'h00;
		stop = 1'b0;
		take = 1'b0;

		if (hp_n == PH_DONE) begin
			stop = 1'b1;
		end

		// second half of a cr lf pair
		if (!stop && lp_n == LN_AFTER_CR && !eod && is_lf) begin
			lp_n = LN_AFTER_NL;
			stop = 1'b1;
		end

		// first byte after a newline: fold or close the header
		if (!stop && lp_n != LN_INSIDE) begin
			if (!eod && byte_s1 == CH_SPACE) begin
				lp_n   = LN_INSIDE;
				cont_n = 1'b1;
				stop   = 1'b1;
			end else begin
				lp_n   = LN_INSIDE;
				cont_n = 1'b0;
				if (hp_n == PH_VALUE) begin
					k0   = K_PAIR;
					n    = 2'd1;
					hp_n = PH_START;
				end else begin
					k0   = K_ERROR;
					n    = 2'd1;
					hp_n = PH_DONE;
					stop = 1'b1;
				end
			end
		end

		// the byte itself
		if (!stop) begin
			if (hp_n == PH_START) begin
				if (eod || is_cr || is_lf) begin
					if (n == 2'd0) begin
						k0 = K_SECTION;
					end else begin
						k1 = K_SECTION;
					end
					n    = n + 2'd1;
					hp_n = PH_DONE;
				end else begin
					take = 1'b1;
				end
			end else if (eod) begin
				if (cont_n) begin
					k0   = K_ERROR;
					n    = 2'd1;
					hp_n = PH_DONE;
				end else begin
					lp_n   = LN_INSIDE;
					cont_n = 1'b0;
					if (hp_n == PH_VALUE) begin
						k0 = K_PAIR;
						k1 = K_SECTION;
						n  = 2'd2;
					end else begin
						k0 = K_ERROR;
						n  = 2'd1;
					end
					hp_n = PH_DONE;
				end
			end else if (is_cr) begin
				lp_n   = LN_AFTER_CR;
				cont_n = 1'b0;
			end else if (is_lf) begin
				lp_n   = LN_AFTER_NL;
				cont_n = 1'b0;
			end else begin
				take = 1'b1;
			end
		end

		// merged header character
		if (take) begin
			if (hp_n == PH_START || hp_n == PH_NAME) begin
				if (byte_s1 == CH_COLON) begin
					hp_n = PH_COLON;
				end else begin
					if (n == 2'd0) begin
						k0 = K_NAME;
						c0 = byte_s1;
					end else begin
						k1 = K_NAME;
						c1 = byte_s1;
					end
					n    = n + 2'd1;
					hp_n = PH_NAME;
				end
			end else if (hp_n == PH_COLON) begin
				if (byte_s1 == CH_SPACE) begin
					hp_n = PH_VALUE;
				end else begin
					k0   = K_ERROR;
					n    = 2'd1;
					hp_n = PH_DONE;
				end
			end else if (hp_n == PH_VALUE) begin
				k0 = K_VALUE;
				c0 = byte_s1;
				n  = 2'd1;
			end
		end

		n_push    = n;
		res0.kind = k0;
		res0.ch   = c0;
		res0.last = (n == 2'd1);
		res1.kind = k1;
		res1.ch   = c1;
		res1.last = 1'b1;
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q   <= PH_DONE;
			lp_q   <= LN_INSIDE;
			cont_q <= 1'b0;
		end else if (advance) begin
			hp_q   <= hp_n;
			lp_q   <= lp_n;
			cont_q <= cont_n;
		end
	end

	// output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			if (advance) begin
				tail_q <= tail_q + QAW'(n_push);
			end
			count_q <= count_q + (advance ? (QAW+1)'(n_push) : '0)
				- (QAW+1)'(pop);
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (advance && n_push != 2'd0) begin
			fifo_q[tail_q] <= res0;
		end
		if (advance && n_push == 2'd2) begin
			fifo_q[tail_q + 1'b1] <= res1;
		end
	end

	// output port
	assign m_tvalid = count_q != '0;
	assign m_tdata  = fifo_q[head_q].ch;
	assign m_tuser  = fifo_q[head_q].kind;
	assign m_tlast  = fifo_q[head_q].last;

	// queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("output queue overflow");

	// two results from one byte always open with pair complete
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && n_push == 2'd2 |-> res0.kind == K_PAIR)
		else $error("double result without pair complete");

	// idle parser stays idle without a first flag
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && hp_q == PH_DONE && !first_s1 |-> n_push == 2'd0 ##1 hp_q == PH_DONE)
		else $error("idle parser produced output or left idle");

	// input is held back whenever the queue lacks room for two results
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && count_q > (QAW+1)'(QDEPTH - 2) |-> !s_tready)
		else $error("request taken without queue room");

endmodule

// ----- verif/header_token_checker.sv -----
// checker for the manifest header line parser: predicts tagged results and compares them
module header_token_checker import mhlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] first
	input  logic       s_tlast,   // end_of_data
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_char
	input  logic [2:0] m_tuser,   // [2:0] kind
	input  logic       m_tlast,   // last
	output int         mismatches,
	output int         awaiting
);
	timeunit 1ns;
	timeprecision 1ps;

	// parse state of the prediction
	hphase_t    hdr_ph    = PH_DONE;
	lphase_t    line_ph   = LN_INSIDE;
	logic       cont_line = 1'b0;

	// results of the byte being predicted, and all results still owed by the block
	result_t    byte_tokens[$];
	result_t    awaited[$];
	result_t    seen;
	result_t    want;

	initial mismatches = 0;
	initial awaiting   = 0;

	// queue one result for the current byte, at most two per byte
	function automatic void add_token(kind_t k, logic [7:0] c);
		result_t r;
		if (byte_tokens.size() < 2) begin
			r.kind = k;
			r.ch   = c;
			r.last = 1'b0;
			byte_tokens.push_back(r);
		end
	endfunction

	// one merged header character
	function automatic void merge_char(logic [7:0] c);
		case (hdr_ph)
			PH_START, PH_NAME: begin
				if (c == CH_COLON) begin
					hdr_ph = PH_COLON;
				end else begin
					add_token(K_NAME, c);
					hdr_ph = PH_NAME;
				end
			end
			PH_COLON: begin
				if (c == CH_SPACE) begin
					hdr_ph = PH_VALUE;
				end else begin
					add_token(K_ERROR, 8'h00);
					hdr_ph = PH_DONE;
				end
			end
			PH_VALUE: add_token(K_VALUE, c);
			default: ;
		endcase
	endfunction

	// header ends; true when a pair completed and parsing goes on
	function automatic logic close_header();
		line_ph   = LN_INSIDE;
		cont_line = 1'b0;
		if (hdr_ph == PH_VALUE) begin
			add_token(K_PAIR, 8'h00);
			hdr_ph = PH_START;
			return 1'b1;
		end
		add_token(K_ERROR, 8'h00);
		hdr_ph = PH_DONE;
		return 1'b0;
	endfunction

	// expected results of one accepted byte request
	function automatic void parse_byte(logic [7:0] b, logic restart, logic eod_flag);
		logic    eod;
		logic    go;
		result_t r;
		eod = eod_flag || (b == CH_NUL);
		go  = 1'b1;
		byte_tokens.delete();
		if (restart) begin
			hdr_ph    = PH_START;
			line_ph   = LN_INSIDE;
			cont_line = 1'b0;
		end
		// newline handling: second half of crlf, folding, or header end
		if (hdr_ph == PH_DONE) begin
			go = 1'b0;
		end else if (line_ph == LN_AFTER_CR && !eod && b == CH_LF) begin
			line_ph = LN_AFTER_NL;
			go = 1'b0;
		end else if (line_ph != LN_INSIDE) begin
			if (!eod && b == CH_SPACE) begin
				line_ph   = LN_INSIDE;
				cont_line = 1'b1;
				go = 1'b0;
			end else if (!close_header()) begin
				go = 1'b0;
			end
		end
		// the byte itself
		if (go) begin
			if (hdr_ph == PH_START) begin
				if (eod || b == CH_CR || b == CH_LF) begin
					add_token(K_SECTION, 8'h00);
					hdr_ph = PH_DONE;
				end else begin
					merge_char(b);
				end
			end else if (eod) begin
				if (cont_line) begin
					add_token(K_ERROR, 8'h00);
					hdr_ph = PH_DONE;
				end else if (close_header()) begin
					add_token(K_SECTION, 8'h00);
					hdr_ph = PH_DONE;
				end
			end else if (b == CH_CR) begin
				line_ph   = LN_AFTER_CR;
				cont_line = 1'b0;
			end else if (b == CH_LF) begin
				line_ph   = LN_AFTER_NL;
				cont_line = 1'b0;
			end else begin
				merge_char(b);
			end
		end
		// mark the final result and hand everything to the waiting list
		if (byte_tokens.size() != 0) begin
			r = byte_tokens.pop_back();
			r.last = 1'b1;
			byte_tokens.push_back(r);
		end
		foreach (byte_tokens[i])
			awaited.push_back(byte_tokens[i]);
	endfunction

	// report a bad result, the first ten in full
	function automatic void report_bad(string what, result_t w, result_t g);
		if (mismatches < 10)
			$display("%s: expected kind %0d char %02h last %0d, got kind %0d char %02h last %0d",
				what, w.kind, w.ch, w.last, g.kind, g.ch, g.last);
		mismatches++;
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_ph    = PH_DONE;
			line_ph   = LN_INSIDE;
			cont_line = 1'b0;
			awaited.delete();
			awaiting <= 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				seen.kind = kind_t'(m_tuser);
				seen.ch   = m_tdata;
				seen.last = m_tlast;
				if (awaited.size() == 0) begin
					report_bad("result with nothing awaited", '0, seen);
				end else begin
					want = awaited.pop_front();
					if (seen.kind !== want.kind || seen.ch !== want.ch || seen.last !== want.last)
						report_bad("result mismatch", want, seen);
				end
			end
			awaiting <= awaited.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// testbench top for the manifest header line parser: byte stimulus, idling and verdict
module tb import mhlp_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 950;

	// one byte request
	typedef struct packed {
		logic [7:0] b;
		logic       f;
		logic       e;
	} byte_req_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
	logic       s_tuser  = 1'b0;    // [0] first
	logic       s_tlast  = 1'b0;    // end_of_data
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_char
	logic [2:0] m_tuser;            // [2:0] kind
	logic       m_tlast;            // last

	int         mismatches;
	int         awaiting;
	int         cycle_cnt  = 0;
	int         gap_pct    = 0;
	int         stall_pct  = 0;
	int         stall_left = 0;
	int         fed        = 0;
	bit         restart_next;
	bit         paused     = 1'b0;
	byte_req_t  script[$];

	always #5 clk = ~clk;

	manifest_header_line_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	header_token_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 17);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic add_req(input logic [7:0] b, input logic f, input logic e);
		byte_req_t r;
		r.b = b;
		r.f = f;
		r.e = e;
		script.push_back(r);
	endtask

	// manifest byte; the first one of a manifest carries the restart flag
	task automatic add_mf(input logic [7:0] b, input logic e);
		add_req(b, restart_next, e);
		restart_next = 1'b0;
	endtask

	task automatic add_newline();
		case ($urandom_range(0, 2))
			0: add_mf(CH_CR, 1'b0);
			1: add_mf(CH_LF, 1'b0);
			default: begin
				add_mf(CH_CR, 1'b0);
				add_mf(CH_LF, 1'b0);
			end
		endcase
	endtask

	function automatic logic [7:0] name_byte();
		logic [7:0] c;
		if ($urandom_range(0, 3) != 0)
			return 8'h41 + 8'($urandom_range(0, 25));
		do c = 8'($urandom_range(1, 255));
		while (c == CH_CR || c == CH_LF || c == CH_COLON);
		return c;
	endfunction

	function automatic logic [7:0] value_byte();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: return CH_COLON;
			1: return CH_SPACE;
			2, 3: begin
				do c = 8'($urandom_range(1, 255));
				while (c == CH_CR || c == CH_LF);
				return c;
			end
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// one manifest: headers with random folding, a few flaws, and a random ending
	task automatic gen_manifest();
		logic [7:0] txt[$];
		int         nh;
		int         flaw;
		int         ending;
		nh = $urandom_range(0, 4);
		ending = $urandom_range(0, 5);
		restart_next = 1'b1;
		for (int h = 0; h < nh; h++) begin
			txt.delete();
			repeat ($urandom_range(1, 6)) txt.push_back(name_byte());
			flaw = $urandom_range(0, 19);
			if (flaw != 0)
				txt.push_back(CH_COLON);
			if (flaw == 2)
				txt.push_back(8'h21 + 8'($urandom_range(0, 90)));
			else if (flaw != 1)
				txt.push_back(CH_SPACE);
			repeat ($urandom_range(0, 8)) txt.push_back(value_byte());
			foreach (txt[i]) begin
				// continuation line inside the header
				if (i > 0 && $urandom_range(0, 7) == 0) begin
					add_newline();
					add_mf(CH_SPACE, 1'b0);
				end
				add_mf(txt[i], 1'b0);
			end
			if (h < nh - 1 || !(ending inside {2, 3}) || $urandom_range(0, 1) == 0)
				add_newline();
		end
		case (ending)
			0, 1: add_newline();
			2: add_mf(8'($urandom_range(0, 255)), 1'b1);
			3: add_mf(CH_NUL, 1'b0);
			4: begin
				// data ends inside a continuation line
				add_mf(CH_SPACE, 1'b0);
				repeat ($urandom_range(0, 3)) add_mf(value_byte(), 1'b0);
				add_mf(8'($urandom_range(0, 255)), 1'b1);
			end
			default: ;
		endcase
	endtask

	// drive every queued request, with random gaps
	task automatic send_script();
		byte_req_t r;
		int        n;
		while (script.size() != 0) begin
			r = script.pop_front();
			if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
				s_tvalid <= 1'b0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= r.b;
			s_tuser  <= r.f;
			s_tlast  <= r.e;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			fed++;
		end
	endtask

	// stop sending until nothing is owed
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle before first, both flags, folding, colons, errors, nul
		gap_pct   = 5;
		stall_pct = 10;
		add_req("A", 1'b0, 1'b0);
		add_req(8'hFF, 1'b1, 1'b1);
		add_req("K", 1'b1, 1'b0);
		add_req(CH_COLON, 1'b0, 1'b0);
		add_req(CH_SPACE, 1'b0, 1'b0);
		add_req(CH_COLON, 1'b0, 1'b0);
		add_req(8'hFF, 1'b0, 1'b0);
		add_req(CH_CR, 1'b0, 1'b0);
		add_req(CH_LF, 1'b0, 1'b0);
		add_req(CH_SPACE, 1'b0, 1'b0);
		add_req("x", 1'b0, 1'b0);
		add_req(CH_LF, 1'b0, 1'b0);
		add_req("N", 1'b0, 1'b0);
		add_req(CH_COLON, 1'b0, 1'b0);
		add_req("z", 1'b0, 1'b0);
		add_req("B", 1'b1, 1'b0);
		add_req(CH_LF, 1'b0, 1'b0);
		add_req(CH_LF, 1'b0, 1'b0);
		add_req(CH_SPACE, 1'b1, 1'b0);
		add_req(CH_COLON, 1'b0, 1'b0);
		add_req(CH_SPACE, 1'b0, 1'b0);
		add_req(CH_LF, 1'b0, 1'b0);
		add_req(CH_SPACE, 1'b0, 1'b0);
		add_req(8'h7E, 1'b0, 1'b1);
		add_req(CH_NUL, 1'b1, 1'b0);
		send_script();

		// random manifests under changing idling, calm at the end
		while (fed < RANDOM_ITEMS) begin
			if (fed > 800) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: begin gap_pct = 0;  stall_pct = 0;  end
					1: begin gap_pct = 5;  stall_pct = 8;  end
					default: begin gap_pct = 25; stall_pct = 35; end
				endcase
			end
			gen_manifest();
			// stray bytes between manifests
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 4))
					add_req(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
						$urandom_range(0, 7) == 0);
			send_script();
			if (!paused && fed > 400) begin
				paused = 1'b1;
				drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
